@@ design/mtstk_pkg.sv @@
// Package for the minimum-tracking stack: shared types and constants.
// No dependencies; every other file of the block uses it.
`timescale 1ns / 1ps
`default_nettype none

package mtstk_pkg;

    localparam int unsigned DATA_W = 32;

    typedef logic signed [DATA_W-1:0] t_data;

    typedef enum logic {
        KIND_PUSH = 1'b0,
        KIND_POP  = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_POP_EMPTY = 2'd1,
        ST_PUSH_FULL = 2'd2
    } t_status;

    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

`default_nettype wire

@@ design/mtstk_if.sv @@
// Channel interfaces for the minimum-tracking stack: request and response.
// Depends on mtstk_pkg for the payload types.
`timescale 1ns / 1ps
`default_nettype none

interface mtstk_req_if;
    logic             valid;
    logic             ready;
    mtstk_pkg::t_kind kind;
    mtstk_pkg::t_data value;

    modport source (output valid, output kind, output value, input ready);
    modport sink   (input valid, input kind, input value, output ready);
endinterface

interface mtstk_rsp_if;
    logic               valid;
    logic               ready;
    mtstk_pkg::t_data   top_value;
    mtstk_pkg::t_data   min_value;
    logic               is_empty;
    mtstk_pkg::t_status status;

    modport source (output valid, output top_value, output min_value,
                    output is_empty, output status, input ready);
    modport sink   (input valid, input top_value, input min_value,
                    input is_empty, input status, output ready);
endinterface

`default_nettype wire

@@ design/mtstk_cell.sv @@
// One entry of a shift-register stack: loads from the cell above on a push
// and from the cell below on a pop. Depends on mtstk_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mtstk_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mtstk_pkg::t_cell_ctrl i_ctrl,
    input  wire mtstk_pkg::t_data      i_above_data,
    input  wire logic                  i_above_valid,
    input  wire mtstk_pkg::t_data      i_below_data,
    input  wire logic                  i_below_valid,
    output mtstk_pkg::t_data           o_data,
    output logic                       o_valid
);

    mtstk_pkg::t_data r_data;
    logic             r_valid;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.push) begin
            r_data <= i_above_data;
        end else if (i_ctrl.pop) begin
            r_data <= i_below_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctrl.push) begin
            r_valid <= i_above_valid;
        end else if (i_ctrl.pop) begin
            r_valid <= i_below_valid;
        end
    end

    assign o_data  = r_data;
    assign o_valid = r_valid;

endmodule

`default_nettype wire

@@ design/mtstk_chain.sv @@
// A stack built as a row of DEPTH cells, top entry in the first cell.
// Depends on mtstk_pkg and mtstk_cell.
`timescale 1ns / 1ps
`default_nettype none

module mtstk_chain #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire mtstk_pkg::t_cell_ctrl i_ctrl,
    input  wire mtstk_pkg::t_data      i_push_data,
    output mtstk_pkg::t_data           o_top_data,
    output logic                       o_top_valid,
    output mtstk_pkg::t_data           o_second_data,
    output logic                       o_second_valid,
    output logic                       o_full
);

    mtstk_pkg::t_data w_data  [DEPTH];
    logic             w_valid [DEPTH];

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        mtstk_pkg::t_data w_above_data;
        logic             w_above_valid;
        mtstk_pkg::t_data w_below_data;
        logic             w_below_valid;

        if (g == 0) begin : g_first
            assign w_above_data  = i_push_data;
            assign w_above_valid = 1'b1;
        end else begin : g_inner_above
            assign w_above_data  = w_data[g-1];
            assign w_above_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_below_data  = '0;
            assign w_below_valid = 1'b0;
        end else begin : g_inner_below
            assign w_below_data  = w_data[g+1];
            assign w_below_valid = w_valid[g+1];
        end

        mtstk_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (i_ctrl),
            .i_above_data  (w_above_data),
            .i_above_valid (w_above_valid),
            .i_below_data  (w_below_data),
            .i_below_valid (w_below_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g])
        );
    end

    assign o_top_data     = w_data[0];
    assign o_top_valid    = w_valid[0];
    assign o_second_data  = w_data[1];
    assign o_second_valid = w_valid[1];
    assign o_full         = w_valid[DEPTH-1];

endmodule

`default_nettype wire

@@ design/min_tracking_stack.sv @@
// Top level of the minimum-tracking stack: two cell chains and the response register.
// Depends on mtstk_pkg, mtstk_if, mtstk_chain and mtstk_cell.
//
// The block takes one push or pop transaction per clock cycle and returns one response
// transaction for each, registered, in the cycle after acceptance. Both the value stack and
// the minimum stack are rows of DEPTH shift cells whose first two cells are read directly,
// so every request reads only the head of each chain and needs no memory access or
// clearing pass after reset. A new request is taken whenever the response register is empty
// or its contents are being taken in the same cycle.
`timescale 1ns / 1ps
`default_nettype none

module min_tracking_stack #(
    parameter int unsigned DEPTH = 64
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    mtstk_req_if.sink   i_req,
    mtstk_rsp_if.source o_rsp
);

    mtstk_pkg::t_cell_ctrl w_val_ctrl;
    mtstk_pkg::t_cell_ctrl w_min_ctrl;
    mtstk_pkg::t_data      w_val_top;
    mtstk_pkg::t_data      w_val_second;
    mtstk_pkg::t_data      w_min_top;
    mtstk_pkg::t_data      w_min_second;
    logic                  w_val_top_valid;
    logic                  w_val_second_valid;
    logic                  w_val_full;
    logic                  w_min_top_valid;
    logic                  w_min_second_valid;
    logic                  w_min_full;

    logic                  w_accept;
    logic                  w_min_le;
    logic                  w_min_drop;

    logic                  r_rsp_valid;
    mtstk_pkg::t_data      r_top;
    mtstk_pkg::t_data      r_min;
    logic                  r_empty;
    mtstk_pkg::t_status    r_status;
    mtstk_pkg::t_data      n_top;
    mtstk_pkg::t_data      n_min;
    logic                  n_empty;
    mtstk_pkg::t_status    n_status;

    mtstk_chain #(.DEPTH(DEPTH)) u_val_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_val_ctrl),
        .i_push_data    (i_req.value),
        .o_top_data     (w_val_top),
        .o_top_valid    (w_val_top_valid),
        .o_second_data  (w_val_second),
        .o_second_valid (w_val_second_valid),
        .o_full         (w_val_full)
    );

    mtstk_chain #(.DEPTH(DEPTH)) u_min_chain (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctrl         (w_min_ctrl),
        .i_push_data    (i_req.value),
        .o_top_data     (w_min_top),
        .o_top_valid    (w_min_top_valid),
        .o_second_data  (w_min_second),
        .o_second_valid (w_min_second_valid),
        .o_full         (w_min_full)
    );

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign w_accept    = i_req.valid && i_req.ready;
    assign w_min_le    = !w_min_top_valid || ($signed(i_req.value) <= $signed(w_min_top));
    assign w_min_drop  = w_min_top_valid && (w_val_top == w_min_top);

    always_comb begin
        w_val_ctrl = '0;
        w_min_ctrl = '0;
        n_top      = w_val_top;
        n_min      = w_min_top;
        n_empty    = 1'b0;
        n_status   = mtstk_pkg::ST_OK;
        unique case (i_req.kind)
            mtstk_pkg::KIND_PUSH: begin
                if (w_val_full) begin
                    n_status = mtstk_pkg::ST_PUSH_FULL;
                end else begin
                    w_val_ctrl.push = w_accept;
                    w_min_ctrl.push = w_accept && w_min_le;
                    n_top           = i_req.value;
                    n_min           = w_min_le ? i_req.value : w_min_top;
                end
            end
            mtstk_pkg::KIND_POP: begin
                if (!w_val_top_valid) begin
                    n_status = mtstk_pkg::ST_POP_EMPTY;
                    n_top    = '0;
                    n_min    = '0;
                    n_empty  = 1'b1;
                end else begin
                    w_val_ctrl.pop = w_accept;
                    w_min_ctrl.pop = w_accept && w_min_drop;
                    n_empty        = !w_val_second_valid;
                    n_top          = w_val_second_valid ? w_val_second : '0;
                    if (!w_val_second_valid) begin
                        n_min = '0;
                    end else if (w_min_drop) begin
                        n_min = w_min_second;
                    end else begin
                        n_min = w_min_top;
                    end
                end
            end
            default: begin
                n_status = mtstk_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (w_accept) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_top    <= n_top;
            r_min    <= n_min;
            r_empty  <= n_empty;
            r_status <= n_status;
        end
    end

    assign o_rsp.valid     = r_rsp_valid;
    assign o_rsp.top_value = r_top;
    assign o_rsp.min_value = r_min;
    assign o_rsp.is_empty  = r_empty;
    assign o_rsp.status    = r_status;

    // The minimum stack never holds more entries than the value stack.
    a_min_within_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_min_top_valid |-> w_val_top_valid)
        else $error("minimum stack holds entries while value stack is empty");

    a_min_not_full_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_min_full |-> w_val_full)
        else $error("minimum stack full before value stack");

    a_min_second: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_min_second_valid |-> w_val_second_valid)
        else $error("minimum stack deeper than value stack");

    a_rsp_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_rsp_valid)
        else $error("accepted request produced no response");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && r_empty) |-> (r_top == '0 && r_min == '0))
        else $error("empty response carries non-zero values");

endmodule

`default_nettype wire

@@ dv/tb_min_tracking_stack.sv @@
// Self-checking testbench for min_tracking_stack: push and pop transactions with random idling
// on both channels, each response checked against a cycle-free stack predictor.
// Depends on mtstk_pkg, mtstk_if and the block's RTL.
`timescale 1ns / 1ps

module tb_min_tracking_stack;

    localparam int DEPTH       = 64;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        mtstk_pkg::t_data   top_value;
        mtstk_pkg::t_data   min_value;
        logic               is_empty;
        mtstk_pkg::t_status status;
    } t_stack_report;

    logic i_clk = 1'b0;
    logic i_rst_n;

    mtstk_req_if req_ch ();
    mtstk_rsp_if rsp_ch ();

    min_tracking_stack #(
        .DEPTH(DEPTH)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_ch),
        .o_rsp  (rsp_ch)
    );

    // Predictor state: the value stack and the stack of running minima.
    mtstk_pkg::t_data value_entries[DEPTH];
    mtstk_pkg::t_data minimum_entries[DEPTH];
    int               value_depth;
    int               minimum_depth;
    t_stack_report    reports_due[$];

    bit src_idle;
    bit snk_idle;
    int snk_stall_left    = 0;
    int stall_drawn_count = 0;
    int rsp_taken_count   = 0;
    int cycle_count       = 0;
    int mismatch_count    = 0;
    int checked_count     = 0;
    int push_count;
    int pop_count;
    int refused_pop_count;
    int refused_push_count;
    int peak_depth;

    always #2 i_clk = ~i_clk;

    function automatic void predict_stack_request(input mtstk_pkg::t_kind kind,
                                                  input mtstk_pkg::t_data value);
        t_stack_report r;
        r.status = mtstk_pkg::ST_OK;
        if (kind == mtstk_pkg::KIND_PUSH) begin
            push_count++;
            if (value_depth >= DEPTH) begin
                r.status = mtstk_pkg::ST_PUSH_FULL;
                refused_push_count++;
            end else begin
                value_entries[value_depth] = value;
                value_depth++;
                if (minimum_depth == 0 || value <= minimum_entries[minimum_depth-1]) begin
                    if (minimum_depth < DEPTH) begin
                        minimum_entries[minimum_depth] = value;
                        minimum_depth++;
                    end
                end
            end
        end else begin
            pop_count++;
            if (value_depth == 0) begin
                r.status = mtstk_pkg::ST_POP_EMPTY;
                refused_pop_count++;
            end else begin
                if (minimum_depth > 0 &&
                    value_entries[value_depth-1] == minimum_entries[minimum_depth-1])
                    minimum_depth--;
                value_depth--;
            end
        end
        if (value_depth > peak_depth)
            peak_depth = value_depth;
        if (value_depth == 0) begin
            r.top_value = '0;
            r.min_value = '0;
            r.is_empty  = 1'b1;
        end else begin
            r.top_value = value_entries[value_depth-1];
            r.min_value = (minimum_depth > 0) ? minimum_entries[minimum_depth-1] : '0;
            r.is_empty  = 1'b0;
        end
        reports_due.push_back(r);
    endfunction

    // Called at a falling edge; returns at the falling edge after the transaction.
    task automatic send_request(input mtstk_pkg::t_kind kind, input mtstk_pkg::t_data value);
        int gap;
        gap = src_idle ? $urandom_range(0, 19) : 0;
        if (gap > 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.kind  <= kind;
        req_ch.value <= value;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_stack_request(kind, value);
        @(negedge i_clk);
    endtask

    function automatic mtstk_pkg::t_data pick_value();
        mtstk_pkg::t_data v;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: begin
                case ($urandom_range(0, 3))
                    0: v = 32'sh7FFF_FFFF;
                    1: v = 32'sh8000_0000;
                    2: v = '0;
                    default: v = -1;
                endcase
            end
            2: v = $urandom_range(0, 8) - 4;
            3: v = 32'sh8000_0000 + $urandom_range(0, 3);
            default: v = $urandom_range(0, 15);
        endcase
        return v;
    endfunction

    // Sink side: per response a random stall, outside the stretches without idling.
    always @(negedge i_clk) begin
        if (stall_drawn_count != rsp_taken_count) begin
            stall_drawn_count = rsp_taken_count;
            snk_stall_left    = snk_idle ? $urandom_range(0, 19) : 0;
        end
        if (snk_stall_left > 0) begin
            rsp_ch.ready <= 1'b0;
            snk_stall_left--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stack_report want;
        t_stack_report seen;
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready) begin
            seen.top_value = rsp_ch.top_value;
            seen.min_value = rsp_ch.min_value;
            seen.is_empty  = rsp_ch.is_empty;
            seen.status    = rsp_ch.status;
            rsp_taken_count++;
            if (reports_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("Unexpected response: top %0d min %0d empty %0b status %s",
                             $signed(seen.top_value), $signed(seen.min_value),
                             seen.is_empty, seen.status.name());
            end else begin
                want = reports_due.pop_front();
                checked_count++;
                if (seen.top_value !== want.top_value || seen.min_value !== want.min_value ||
                    seen.is_empty !== want.is_empty || seen.status !== want.status) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Mismatch on response %0d: expected top %0d min %0d empty %0b status %0d",
                                 checked_count, $signed(want.top_value),
                                 $signed(want.min_value), want.is_empty, want.status);
                        $display("    got top %0d min %0d empty %0b status %0d",
                                 $signed(seen.top_value), $signed(seen.min_value),
                                 seen.is_empty, seen.status);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycle_count, reports_due.size());
            $display("FAIL");
            $finish;
        end
    end

    // Minimum duplicates, extreme values and pops on an empty stack.
    task automatic test_directed_cases();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        send_request(mtstk_pkg::KIND_POP, 32'sh7FFF_FFFF);
        send_request(mtstk_pkg::KIND_PUSH, 5);
        send_request(mtstk_pkg::KIND_PUSH, 7);
        send_request(mtstk_pkg::KIND_PUSH, 5);
        send_request(mtstk_pkg::KIND_PUSH, 32'sh7FFF_FFFF);
        send_request(mtstk_pkg::KIND_PUSH, 32'sh8000_0000);
        send_request(mtstk_pkg::KIND_PUSH, 32'sh8000_0000);
        send_request(mtstk_pkg::KIND_PUSH, -1);
        repeat (7) send_request(mtstk_pkg::KIND_POP, -1);
        send_request(mtstk_pkg::KIND_POP, '0);
        send_request(mtstk_pkg::KIND_PUSH, '0);
        send_request(mtstk_pkg::KIND_PUSH, -1);
        send_request(mtstk_pkg::KIND_POP, 32'sh8000_0000);
        send_request(mtstk_pkg::KIND_POP, '0);
    endtask

    // Fill to capacity, offer pushes that must be refused, then drain past empty.
    task automatic test_fill_and_drain();
        src_idle = 1'b1;
        snk_idle = 1'b1;
        while (value_depth < DEPTH) send_request(mtstk_pkg::KIND_PUSH, pick_value());
        repeat (3) send_request(mtstk_pkg::KIND_PUSH, pick_value());
        src_idle = 1'b0;
        snk_idle = 1'b1;
        while (value_depth > 0) send_request(mtstk_pkg::KIND_POP, $urandom);
        repeat (2) send_request(mtstk_pkg::KIND_POP, $urandom);
    endtask

    // Segments of rising, falling and balanced traffic with mixed idling.
    task automatic test_random_walk();
        int push_pct;
        repeat (16) begin
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 25;
                default: push_pct = 50;
            endcase
            src_idle = $urandom_range(0, 2) != 0;
            snk_idle = $urandom_range(0, 2) != 0;
            repeat (25) begin
                if ($urandom_range(0, 99) < push_pct)
                    send_request(mtstk_pkg::KIND_PUSH, pick_value());
                else
                    send_request(mtstk_pkg::KIND_POP, $urandom);
            end
        end
    endtask

    initial begin
        req_ch.valid       = 1'b0;
        req_ch.kind        = mtstk_pkg::KIND_PUSH;
        req_ch.value       = '0;
        value_depth        = 0;
        minimum_depth      = 0;
        push_count         = 0;
        pop_count          = 0;
        refused_pop_count  = 0;
        refused_push_count = 0;
        peak_depth         = 0;
        src_idle           = 1'b0;
        snk_idle           = 1'b0;
        i_rst_n            = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_directed_cases();
        test_fill_and_drain();
        test_random_walk();

        req_ch.valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d responses: %0d pushes (%0d refused when full), %0d pops",
                 checked_count, push_count, refused_push_count, pop_count);
        $display("(%0d refused when empty), deepest stack %0d, %0d mismatches.",
                 refused_pop_count, peak_depth, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ min_tracking_stack.f @@
design/mtstk_pkg.sv
design/mtstk_if.sv
design/mtstk_cell.sv
design/mtstk_chain.sv
design/min_tracking_stack.sv
dv/tb_min_tracking_stack.sv
